// File: design/rv32ss_pkg.sv
`timescale 1ns / 1ps

package rv32ss_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned REG_AW   = 5;
  localparam int unsigned NUM_REGS = 1 << REG_AW;

  localparam logic [XLEN-1:0] START_PC_RST = 32'h0000_0200;
  localparam logic [XLEN-1:0] JALR_MASK    = 32'hffff_fffe;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_WORD = 3'd2;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MUL  = 7'h01;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  typedef struct packed {
    logic [XLEN-1:0]   trace_pc;
    logic [REG_AW-1:0] dest_reg;
    logic [XLEN-1:0]   write_value;
    logic              write_enable;
    logic [1:0]        mem_op;
    logic [XLEN-1:0]   mem_address;
    logic [XLEN-1:0]   store_data;
    logic [XLEN-1:0]   next_pc;
    logic              illegal;
  } trace_t;

  typedef struct packed {
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [XLEN-1:0]   rf_wdata;
    logic [XLEN-1:0]   pc_nxt;
    logic              ld_set;
    logic              ld_clr;
    logic [REG_AW-1:0] ld_dest;
    logic [XLEN-1:0]   ld_pc;
  } upd_t;

endpackage

// File: design/rv32ss_regfile.sv
`timescale 1ns / 1ps

module rv32ss_regfile import rv32ss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [REG_AW-1:0] rd_addr_a,
  input  logic [REG_AW-1:0] rd_addr_b,
  output logic [XLEN-1:0]   rd_data_a,
  output logic [XLEN-1:0]   rd_data_b,
  input  logic              wr_en,
  input  logic [REG_AW-1:0] wr_addr,
  input  logic [XLEN-1:0]   wr_data
);

  logic [XLEN-1:0]     mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [XLEN-1:0]     q_a_r;
  logic [XLEN-1:0]     q_b_r;
  logic                qv_a_r;
  logic                qv_b_r;
  logic [REG_AW-1:0]   ra_a_r;
  logic [REG_AW-1:0]   ra_b_r;
  logic                wb_v_r;
  logic [REG_AW-1:0]   wb_addr_r;
  logic [XLEN-1:0]     wb_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a_r  <= mem[rd_addr_a];
      q_b_r  <= mem[rd_addr_b];
      qv_a_r <= vld_r[rd_addr_a];
      qv_b_r <= vld_r[rd_addr_b];
      ra_a_r <= rd_addr_a;
      ra_b_r <= rd_addr_b;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      wb_v_r <= 1'b0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
      wb_v_r         <= 1'b1;
    end
  end

  // last write, forwarded over a read issued at the same edge
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr_r <= wr_addr;
      wb_data_r <= wr_data;
    end
  end

  always_comb begin
    if (wb_v_r && wb_addr_r == ra_a_r) begin
      rd_data_a = wb_data_r;
    end else begin
      rd_data_a = qv_a_r ? q_a_r : '0;
    end
    if (wb_v_r && wb_addr_r == ra_b_r) begin
      rd_data_b = wb_data_r;
    end else begin
      rd_data_b = qv_b_r ? q_b_r : '0;
    end
  end

endmodule

// File: design/rv32ss_exec.sv
`timescale 1ns / 1ps

module rv32ss_exec import rv32ss_pkg::*; (
  input  logic              kind,
  input  logic [XLEN-1:0]   instr,
  input  logic [XLEN-1:0]   load_data,
  input  logic [XLEN-1:0]   a,
  input  logic [XLEN-1:0]   b,
  input  logic [XLEN-1:0]   pc,
  input  logic              ld_pend,
  input  logic [REG_AW-1:0] ld_dest,
  input  logic [XLEN-1:0]   ld_pc,
  output trace_t            res,
  output upd_t              upd
);

  logic [6:0]        opc;
  logic [REG_AW-1:0] rd;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [4:0]        shamt_i;
  logic [XLEN-1:0]   immi;
  logic [XLEN-1:0]   imms;
  logic [XLEN-1:0]   immb;
  logic [XLEN-1:0]   immj;
  logic [XLEN-1:0]   immu;
  logic [XLEN-1:0]   prod;
  logic [XLEN-1:0]   pc4;
  logic              ok;
  logic              wr;
  logic              taken;
  logic              ldc;
  logic [XLEN-1:0]   val;
  logic [XLEN-1:0]   npc;
  logic [1:0]        op;
  logic [XLEN-1:0]   addr;
  logic [XLEN-1:0]   sdata;
  logic [REG_AW-1:0] dst;

  assign opc     = instr[6:0];
  assign rd      = instr[11:7];
  assign f3      = instr[14:12];
  assign f7      = instr[31:25];
  assign shamt_i = instr[24:20];
  assign immi    = {{20{instr[31]}}, instr[31:20]};
  assign imms    = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign immb    = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign immj    = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign immu    = {instr[31:12], 12'b0};
  assign prod    = a * b;
  assign pc4     = pc + 32'd4;

  always_comb begin
    ok    = 1'b1;
    wr    = 1'b0;
    taken = 1'b0;
    ldc   = 1'b0;
    val   = '0;
    npc   = pc4;
    op    = MEM_NONE;
    addr  = '0;
    sdata = '0;
    if (kind) begin
      if (ld_pend) begin
        ldc = 1'b1;
      end else begin
        ok = 1'b0;
      end
    end else if (ld_pend) begin
      ok = 1'b0;
    end else begin
      case (opc)
        OPC_OP: begin
          wr = 1'b1;
          if (f7 == F7_BASE) begin
            case (f3)
              F3_ADD:  val = a + b;
              F3_SLL:  val = a << b[4:0];
              F3_SLT:  val = {31'b0, $signed(a) < $signed(b)};
              F3_SLTU: val = {31'b0, a < b};
              F3_XOR:  val = a ^ b;
              F3_SR:   val = a >> b[4:0];
              F3_OR:   val = a | b;
              F3_AND:  val = a & b;
              default: val = '0;
            endcase
          end else if (f7 == F7_ALT && f3 == F3_ADD) begin
            val = a - b;
          end else if (f7 == F7_ALT && f3 == F3_SR) begin
            val = $unsigned($signed(a) >>> b[4:0]);
          end else if (f7 == F7_MUL && f3 == F3_ADD) begin
            val = prod;
          end else begin
            ok = 1'b0;
          end
        end
        OPC_OP_IMM: begin
          wr = 1'b1;
          case (f3)
            F3_ADD:  val = a + immi;
            F3_SLT:  val = {31'b0, $signed(a) < $signed(immi)};
            F3_SLTU: val = {31'b0, a < immi};
            F3_XOR:  val = a ^ immi;
            F3_OR:   val = a | immi;
            F3_AND:  val = a & immi;
            F3_SLL: begin
              if (f7 == F7_BASE) begin
                val = a << shamt_i;
              end else begin
                ok = 1'b0;
              end
            end
            F3_SR: begin
              if (f7 == F7_BASE) begin
                val = a >> shamt_i;
              end else if (f7 == F7_ALT) begin
                val = $unsigned($signed(a) >>> shamt_i);
              end else begin
                ok = 1'b0;
              end
            end
            default: ok = 1'b0;
          endcase
        end
        OPC_LUI: begin
          wr  = 1'b1;
          val = immu;
        end
        OPC_AUIPC: begin
          wr  = 1'b1;
          val = pc + immu;
        end
        OPC_JAL: begin
          wr  = 1'b1;
          val = pc4;
          npc = pc + immj;
        end
        OPC_JALR: begin
          if (f3 == F3_ADD) begin
            wr  = 1'b1;
            val = pc4;
            npc = (a + immi) & JALR_MASK;
          end else begin
            ok = 1'b0;
          end
        end
        OPC_LOAD: begin
          if (f3 == F3_WORD) begin
            op   = MEM_LOAD;
            addr = a + immi;
          end else begin
            ok = 1'b0;
          end
        end
        OPC_STORE: begin
          if (f3 == F3_WORD) begin
            op    = MEM_STORE;
            addr  = a + imms;
            sdata = b;
          end else begin
            ok = 1'b0;
          end
        end
        OPC_BRANCH: begin
          case (f3)
            F3_BEQ:  taken = (a == b);
            F3_BNE:  taken = (a != b);
            F3_BLT:  taken = $signed(a) < $signed(b);
            F3_BGE:  taken = !($signed(a) < $signed(b));
            F3_BLTU: taken = a < b;
            F3_BGEU: taken = a >= b;
            default: ok = 1'b0;
          endcase
          if (taken) begin
            npc = pc + immb;
          end
        end
        default: ok = 1'b0;
      endcase
    end
  end

  assign dst = (wr || op == MEM_LOAD) ? rd : '0;

  always_comb begin
    res         = '0;
    upd         = '0;
    upd.pc_nxt  = pc;
    upd.ld_dest = rd;
    upd.ld_pc   = pc;
    if (!ok) begin
      res.trace_pc = pc;
      res.next_pc  = pc;
      res.illegal  = 1'b1;
    end else if (ldc) begin
      res.trace_pc     = ld_pc;
      res.dest_reg     = ld_dest;
      res.write_value  = (ld_dest != '0) ? load_data : '0;
      res.write_enable = (ld_dest != '0);
      res.next_pc      = pc;
      upd.rf_we        = (ld_dest != '0);
      upd.rf_waddr     = ld_dest;
      upd.rf_wdata     = load_data;
      upd.ld_clr       = 1'b1;
    end else begin
      res.trace_pc     = pc;
      res.dest_reg     = dst;
      res.write_value  = (wr && rd != '0) ? val : '0;
      res.write_enable = wr && rd != '0;
      res.mem_op       = op;
      res.mem_address  = addr;
      res.store_data   = sdata;
      res.next_pc      = npc;
      upd.rf_we        = wr && rd != '0;
      upd.rf_waddr     = rd;
      upd.rf_wdata     = val;
      upd.pc_nxt       = npc;
      upd.ld_set       = (op == MEM_LOAD);
    end
  end

endmodule

// File: design/rv32_subset_instruction_step.sv
`timescale 1ns / 1ps

// RV32I subset plus MUL, one trace beat out for each beat in. An item is taken
// every cycle unless the execute stage is stalled; its result is offered after the
// register file read at the accepting edge and execute into the output register;
// output back-pressure stalls execute. Registers live in a 32 x 32 memory with two
// synchronous read ports; the last write is forwarded to a read issued at the same
// edge, and per-entry valid bits make the file read zero after reset with no clearing
// pass. A write to cfg_start_pc loads the pc at once and must only be made while idle.
module rv32_subset_instruction_step import rv32ss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [XLEN-1:0]   cfg_start_pc,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [XLEN-1:0]   in_instr_word,
  input  logic [XLEN-1:0]   in_load_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [XLEN-1:0]   out_trace_pc,
  output logic [REG_AW-1:0] out_dest_reg,
  output logic [XLEN-1:0]   out_write_value,
  output logic              out_write_enable,
  output logic [1:0]        out_mem_op,
  output logic [XLEN-1:0]   out_mem_address,
  output logic [XLEN-1:0]   out_store_data,
  output logic [XLEN-1:0]   out_next_pc,
  output logic              out_illegal
);

  logic              in_fire;
  logic              ex_fire;
  logic              cfg_fire;
  logic              ex_valid_r;
  logic              ex_valid_nxt;
  logic              ex_kind_r;
  logic [XLEN-1:0]   ex_instr_r;
  logic [XLEN-1:0]   ex_ld_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  trace_t            out_r;
  logic [XLEN-1:0]   pc_r;
  logic [XLEN-1:0]   pc_nxt;
  logic              ld_pend_r;
  logic              ld_pend_nxt;
  logic [REG_AW-1:0] ld_dest_r;
  logic [REG_AW-1:0] ld_dest_nxt;
  logic [XLEN-1:0]   ld_pc_r;
  logic [XLEN-1:0]   ld_pc_nxt;
  logic [XLEN-1:0]   op_a;
  logic [XLEN-1:0]   op_b;
  trace_t            res;
  upd_t              upd;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign ex_fire   = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !ex_valid_r || ex_fire;
  assign in_fire   = in_valid && in_ready;

  rv32ss_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (in_instr_word[19:15]),
    .rd_addr_b (in_instr_word[24:20]),
    .rd_data_a (op_a),
    .rd_data_b (op_b),
    .wr_en     (ex_fire && upd.rf_we),
    .wr_addr   (upd.rf_waddr),
    .wr_data   (upd.rf_wdata)
  );

  rv32ss_exec u_exec (
    .kind      (ex_kind_r),
    .instr     (ex_instr_r),
    .load_data (ex_ld_data_r),
    .a         (op_a),
    .b         (op_b),
    .pc        (pc_r),
    .ld_pend   (ld_pend_r),
    .ld_dest   (ld_dest_r),
    .ld_pc     (ld_pc_r),
    .res       (res),
    .upd       (upd)
  );

  always_comb begin
    ex_valid_nxt  = in_fire ? 1'b1 : (ex_fire ? 1'b0 : ex_valid_r);
    out_valid_nxt = ex_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    pc_nxt        = pc_r;
    ld_pend_nxt   = ld_pend_r;
    ld_dest_nxt   = ld_dest_r;
    ld_pc_nxt     = ld_pc_r;
    if (cfg_fire) begin
      pc_nxt = cfg_start_pc;
    end else if (ex_fire) begin
      pc_nxt = upd.pc_nxt;
      if (upd.ld_set) begin
        ld_pend_nxt = 1'b1;
        ld_dest_nxt = upd.ld_dest;
        ld_pc_nxt   = upd.ld_pc;
      end else if (upd.ld_clr) begin
        ld_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= START_PC_RST;
      ld_pend_r   <= 1'b0;
      ld_dest_r   <= '0;
      ld_pc_r     <= '0;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      ld_pend_r   <= ld_pend_nxt;
      ld_dest_r   <= ld_dest_nxt;
      ld_pc_r     <= ld_pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_kind_r    <= in_kind;
      ex_instr_r   <= in_instr_word;
      ex_ld_data_r <= in_load_data;
    end
    if (ex_fire) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trace_pc     = out_r.trace_pc;
  assign out_dest_reg     = out_r.dest_reg;
  assign out_write_value  = out_r.write_value;
  assign out_write_enable = out_r.write_enable;
  assign out_mem_op       = out_r.mem_op;
  assign out_mem_address  = out_r.mem_address;
  assign out_store_data   = out_r.store_data;
  assign out_next_pc      = out_r.next_pc;
  assign out_illegal      = out_r.illegal;

`ifndef NO_ASSERTIONS
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && upd.rf_we |-> upd.rf_waddr != '0)
    else $error("register write to x0");

  a_load_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && res.mem_op == MEM_LOAD && !res.illegal |=> ld_pend_r)
    else $error("load issued without pending record");

  a_illegal_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && res.illegal |=> pc_r == $past(pc_r))
    else $error("illegal item changed pc");

  a_we_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.write_enable |-> out_r.dest_reg != '0 && !out_r.illegal)
    else $error("write enable with no destination");
`endif

endmodule

// File: tb/tb_rv32_subset_instruction_step.sv
`timescale 1ns / 1ps

module tb_rv32_subset_instruction_step;
  import rv32ss_pkg::*;

  localparam logic [6:0] F7_BAD = 7'h7f;

  typedef struct packed {
    logic            kind;
    logic [XLEN-1:0] word;
    logic [XLEN-1:0] data;
  } in_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [XLEN-1:0]   cfg_start_pc = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_kind = 1'b0;
  logic [XLEN-1:0]   in_instr_word = '0;
  logic [XLEN-1:0]   in_load_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [XLEN-1:0]   out_trace_pc;
  logic [REG_AW-1:0] out_dest_reg;
  logic [XLEN-1:0]   out_write_value;
  logic              out_write_enable;
  logic [1:0]        out_mem_op;
  logic [XLEN-1:0]   out_mem_address;
  logic [XLEN-1:0]   out_store_data;
  logic [XLEN-1:0]   out_next_pc;
  logic              out_illegal;

  // architectural state of the predictor
  logic [XLEN-1:0]   gpr [NUM_REGS];
  logic [XLEN-1:0]   model_pc = START_PC_RST;
  logic [XLEN-1:0]   start_pc_cfg = START_PC_RST;
  logic              load_waiting = 1'b0;
  logic [REG_AW-1:0] load_rd = '0;
  logic [XLEN-1:0]   load_pc_saved = '0;

  in_beat_t    pending_beats [$];
  trace_t      trace_expect [$];
  int unsigned beats_queued = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  logic        gen_load_open = 1'b0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned gap_max = 0;
  in_beat_t    drv_beat;

  logic        stall_on = 1'b0;
  logic        stall_heavy = 1'b0;
  logic        long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  logic [31:0] ready_pattern = '1;
  logic [4:0]  pattern_pos = '0;

  trace_t      mon_seen;
  trace_t      mon_want;
  string       mon_diff;

  rv32_subset_instruction_step i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_start_pc     (cfg_start_pc),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_instr_word    (in_instr_word),
    .in_load_data     (in_load_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_trace_pc     (out_trace_pc),
    .out_dest_reg     (out_dest_reg),
    .out_write_value  (out_write_value),
    .out_write_enable (out_write_enable),
    .out_mem_op       (out_mem_op),
    .out_mem_address  (out_mem_address),
    .out_store_data   (out_store_data),
    .out_next_pc      (out_next_pc),
    .out_illegal      (out_illegal)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // instruction encoders
  function automatic logic [31:0] r_op(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] i_op(logic [6:0] opc, logic [11:0] imm, logic [4:0] rs1,
                                       logic [2:0] f3, logic [4:0] rd);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] s_op(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                       logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] b_op(logic [2:0] f3, logic [12:0] imm, logic [4:0] rs2,
                                       logic [4:0] rs1);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] u_op(logic [6:0] opc, logic [19:0] imm, logic [4:0] rd);
    return {imm, rd, opc};
  endfunction

  function automatic logic [31:0] j_op(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic trace_t execute_beat(logic kind, logic [31:0] w, logic [31:0] ldata);
    trace_t      t;
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] pc, a, b, imm_i, imm_s, imm_b, imm_j, val, npc;
    logic        ok, wr, taken;
    pc = model_pc;
    opc = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = gpr[w[19:15]];
    b = gpr[w[24:20]];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    val = '0;
    npc = pc + 32'd4;
    ok = 1'b1;
    wr = 1'b0;
    taken = 1'b0;
    t = '0;
    t.trace_pc = pc;
    t.next_pc = pc;
    if (kind) begin
      if (load_waiting) begin
        load_waiting = 1'b0;
        t.trace_pc = load_pc_saved;
        t.dest_reg = load_rd;
        if (load_rd != '0) begin
          gpr[load_rd] = ldata;
          t.write_value = ldata;
          t.write_enable = 1'b1;
        end
      end else begin
        t.illegal = 1'b1;
      end
      return t;
    end
    if (load_waiting) begin
      t.illegal = 1'b1;
      return t;
    end
    case (opc)
      OPC_OP: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = a + b;
            F3_SLL:  val = a << b[4:0];
            F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  val = a ^ b;
            F3_SR:   val = a >> b[4:0];
            F3_OR:   val = a | b;
            F3_AND:  val = a & b;
            default: val = '0;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          val = a - b;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          val = $signed(a) >>> b[4:0];
        end else if (f7 == F7_MUL && f3 == F3_ADD) begin
          val = a * b;
        end else begin
          ok = 1'b0;
        end
      end
      OPC_OP_IMM: begin
        wr = 1'b1;
        case (f3)
          F3_ADD:  val = a + imm_i;
          F3_SLT:  val = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
          F3_SLTU: val = (a < imm_i) ? 32'd1 : 32'd0;
          F3_XOR:  val = a ^ imm_i;
          F3_OR:   val = a | imm_i;
          F3_AND:  val = a & imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) val = a << w[24:20];
            else ok = 1'b0;
          end
          F3_SR: begin
            if (f7 == F7_BASE) val = a >> w[24:20];
            else if (f7 == F7_ALT) val = $signed(a) >>> w[24:20];
            else ok = 1'b0;
          end
          default: ok = 1'b0;
        endcase
      end
      OPC_LUI: begin
        wr = 1'b1;
        val = {w[31:12], 12'b0};
      end
      OPC_AUIPC: begin
        wr = 1'b1;
        val = pc + {w[31:12], 12'b0};
      end
      OPC_JAL: begin
        wr = 1'b1;
        val = pc + 32'd4;
        npc = pc + imm_j;
      end
      OPC_JALR: begin
        if (f3 != F3_ADD) begin
          ok = 1'b0;
        end else begin
          wr = 1'b1;
          val = pc + 32'd4;
          npc = (a + imm_i) & JALR_MASK;
        end
      end
      OPC_LOAD: begin
        if (f3 != F3_WORD) begin
          ok = 1'b0;
        end else begin
          load_waiting = 1'b1;
          load_rd = rd;
          load_pc_saved = pc;
          model_pc = npc;
          t.dest_reg = rd;
          t.mem_op = MEM_LOAD;
          t.mem_address = a + imm_i;
          t.next_pc = npc;
          return t;
        end
      end
      OPC_STORE: begin
        if (f3 != F3_WORD) begin
          ok = 1'b0;
        end else begin
          model_pc = npc;
          t.mem_op = MEM_STORE;
          t.mem_address = a + imm_s;
          t.store_data = b;
          t.next_pc = npc;
          return t;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = ($signed(a) < $signed(b));
          F3_BGE:  taken = ($signed(a) >= $signed(b));
          F3_BLTU: taken = (a < b);
          F3_BGEU: taken = (a >= b);
          default: ok = 1'b0;
        endcase
        if (taken) npc = pc + imm_b;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      t.illegal = 1'b1;
      return t;
    end
    if (wr && rd != '0) begin
      gpr[rd] = val;
      t.dest_reg = rd;
      t.write_value = val;
      t.write_enable = 1'b1;
    end
    model_pc = npc;
    t.next_pc = npc;
    return t;
  endfunction

  function automatic string trace_text(trace_t t);
    return $sformatf("pc=%h rd=%0d val=%h we=%b mem=%0d addr=%h sd=%h npc=%h ill=%b",
                     t.trace_pc, t.dest_reg, t.write_value, t.write_enable, t.mem_op,
                     t.mem_address, t.store_data, t.next_pc, t.illegal);
  endfunction

  task automatic log_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic logic [4:0] pick_reg();
    logic [4:0] r;
    if ($urandom_range(0, 3) == 0) r = 5'($urandom_range(0, 31));
    else r = 5'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic logic [2:0] rare_f3(logic [2:0] f3);
    logic [2:0] r;
    r = 3'($urandom);
    return ($urandom_range(0, 9) == 0) ? r : f3;
  endfunction

  function automatic logic [31:0] random_instr();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] imm;
    logic [31:0] w;
    int unsigned pick;
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = ($urandom_range(0, 5) == 0) ? rs1 : pick_reg();
    f3 = 3'($urandom);
    imm = 12'($urandom);
    f7 = F7_BASE;
    pick = $urandom_range(0, 15);
    if (pick < 4) begin
      case ($urandom_range(0, 11))
        8: begin
          f7 = F7_ALT;
          f3 = F3_ADD;
        end
        9: begin
          f7 = F7_ALT;
          f3 = F3_SR;
        end
        10: begin
          f7 = F7_MUL;
          f3 = F3_ADD;
        end
        11: f7 = 7'($urandom);
        default: f7 = F7_BASE;
      endcase
      w = r_op(f7, rs2, rs1, f3, rd);
    end else if (pick < 8) begin
      if (f3 == F3_SLL || f3 == F3_SR) begin
        case ($urandom_range(0, 4))
          0, 1: imm[11:5] = F7_BASE;
          2, 3: imm[11:5] = F7_ALT;
          default: imm[11:5] = 7'($urandom);
        endcase
      end
      w = i_op(OPC_OP_IMM, imm, rs1, f3, rd);
    end else begin
      case (pick)
        8: w = u_op(OPC_LUI, 20'($urandom), rd);
        9: w = u_op(OPC_AUIPC, 20'($urandom), rd);
        10: w = j_op(21'($urandom), rd);
        11: w = i_op(OPC_JALR, imm, rs1, rare_f3(F3_ADD), rd);
        12, 13: w = i_op(OPC_LOAD, imm, rs1, rare_f3(F3_WORD), rd);
        14: w = s_op(imm, rs2, rs1, rare_f3(F3_WORD));
        default: w = b_op(f3, 13'($urandom), rs2, rs1);
      endcase
    end
    return w;
  endfunction

  task automatic send_instr(logic [31:0] w);
    pending_beats.push_back('{kind: 1'b0, word: w, data: $urandom});
    beats_queued++;
    if (!gen_load_open && w[6:0] == OPC_LOAD && w[14:12] == F3_WORD) gen_load_open = 1'b1;
  endtask

  task automatic send_load(logic [31:0] d);
    pending_beats.push_back('{kind: 1'b1, word: $urandom, data: d});
    beats_queued++;
    gen_load_open = 1'b0;
  endtask

  // mostly legal programs with load data following each load, plus some noise
  task automatic queue_random_items(int unsigned count);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 31);
      if (gen_load_open) begin
        if (roll == 0) send_instr(random_instr());
        else send_load($urandom);
      end else if (roll == 0) begin
        send_load($urandom);
      end else if (roll == 1) begin
        send_instr($urandom);
      end else begin
        send_instr(random_instr());
      end
    end
  endtask

  task automatic wait_idle();
    while (results_seen < beats_queued) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] v);
    cfg_start_pc <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_pc_cfg = v;
    model_pc = v;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) trace_expect.push_back(execute_beat(in_kind, in_instr_word,
                                                                   in_load_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          drv_beat = pending_beats.pop_front();
          in_kind <= drv_beat.kind;
          in_instr_word <= drv_beat.word;
          in_load_data <= drv_beat.data;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = $urandom_range(0, gap_max);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver with its own stall pattern and long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (long_hold_req) begin
        hold_left = 400;
        long_hold_req = 1'b0;
      end
      if (pattern_pos == '0) ready_pattern = stall_heavy ? ($urandom & $urandom)
                                                         : ($urandom | $urandom);
      pattern_pos = pattern_pos + 5'd1;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !stall_on || ready_pattern[pattern_pos];
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      mon_seen = {out_trace_pc, out_dest_reg, out_write_value, out_write_enable, out_mem_op,
                  out_mem_address, out_store_data, out_next_pc, out_illegal};
      if (trace_expect.size() == 0) begin
        log_failure({"result beat with nothing expected: ", trace_text(mon_seen)});
      end else begin
        mon_want = trace_expect.pop_front();
        mon_diff = "";
        if (mon_seen.trace_pc !== mon_want.trace_pc) mon_diff = {mon_diff, " trace_pc"};
        if (mon_seen.dest_reg !== mon_want.dest_reg) mon_diff = {mon_diff, " dest_reg"};
        if (mon_seen.write_value !== mon_want.write_value) mon_diff = {mon_diff, " write_value"};
        if (mon_seen.write_enable !== mon_want.write_enable)
          mon_diff = {mon_diff, " write_enable"};
        if (mon_seen.mem_op !== mon_want.mem_op) mon_diff = {mon_diff, " mem_op"};
        if (mon_seen.mem_address !== mon_want.mem_address) mon_diff = {mon_diff, " mem_address"};
        if (mon_seen.store_data !== mon_want.store_data) mon_diff = {mon_diff, " store_data"};
        if (mon_seen.next_pc !== mon_want.next_pc) mon_diff = {mon_diff, " next_pc"};
        if (mon_seen.illegal !== mon_want.illegal) mon_diff = {mon_diff, " illegal"};
        if (mon_diff != "")
          log_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s", mon_diff,
                                trace_text(mon_want), trace_text(mon_seen)));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: operand extremes, x0 destination, load sequencing, illegal forms
    send_instr(i_op(OPC_OP_IMM, 12'hfff, 5'd0, F3_ADD, 5'd1));
    send_instr(i_op(OPC_OP_IMM, 12'h7ff, 5'd0, F3_ADD, 5'd2));
    send_instr(u_op(OPC_LUI, 20'h80000, 5'd3));
    send_instr(r_op(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0));
    send_instr(r_op(F7_ALT, 5'd1, 5'd3, F3_ADD, 5'd4));
    send_instr(r_op(F7_MUL, 5'd3, 5'd1, F3_ADD, 5'd5));
    send_instr(r_op(F7_ALT, 5'd1, 5'd3, F3_SR, 5'd6));
    send_instr(r_op(F7_BASE, 5'd1, 5'd3, F3_SR, 5'd7));
    send_instr(r_op(F7_BASE, 5'd2, 5'd3, F3_SLT, 5'd8));
    send_instr(r_op(F7_BASE, 5'd2, 5'd3, F3_SLTU, 5'd9));
    send_instr(u_op(OPC_AUIPC, 20'hfffff, 5'd10));
    send_instr(i_op(OPC_LOAD, 12'hffc, 5'd1, F3_WORD, 5'd11));
    send_instr(i_op(OPC_OP_IMM, 12'h001, 5'd1, F3_ADD, 5'd12));
    send_load(32'hffff_ffff);
    send_instr(i_op(OPC_LOAD, 12'h800, 5'd2, F3_WORD, 5'd0));
    send_load(32'h1234_5678);
    send_load(32'h0000_0000);
    send_instr(s_op(12'h7ff, 5'd1, 5'd3, F3_WORD));
    send_instr(b_op(F3_BEQ, 13'h1000, 5'd1, 5'd1));
    send_instr(b_op(F3_BNE, 13'h0ffe, 5'd0, 5'd0));
    send_instr(j_op(21'h0ffffe, 5'd0));
    send_instr(i_op(OPC_JALR, 12'hfff, 5'd1, F3_ADD, 5'd12));
    send_instr(32'hffff_ffff);
    send_instr(32'h0000_0000);
    send_instr(r_op(F7_BAD, 5'd2, 5'd1, F3_ADD, 5'd13));
    // funct3 of two is not a branch
    send_instr(b_op(F3_SLT, 13'h0004, 5'd2, 5'd1));
    wait_idle();

    write_start_pc(32'hffff_fffc);
    gap_max = 4;
    stall_on = 1'b1;
    queue_random_items(200);
    wait_idle();

    write_start_pc(32'h0000_0000);
    gap_max = 0;
    stall_on = 1'b0;
    long_hold_req = 1'b1;
    queue_random_items(200);
    wait_idle();

    write_start_pc(32'hffff_ffff);
    gap_max = 8;
    stall_on = 1'b1;
    stall_heavy = 1'b1;
    queue_random_items(200);
    wait_idle();

    write_start_pc($urandom);
    gap_max = 3;
    stall_heavy = 1'b0;
    queue_random_items(200);
    wait_idle();

    write_start_pc(START_PC_RST);
    gap_max = 1;
    queue_random_items(200);
    wait_idle();

    repeat (8) @(posedge clk);
    if (trace_expect.size() != 0)
      log_failure($sformatf("%0d expected results never arrived", trace_expect.size()));
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
